// File: rtl/gble_pkg.sv
// ----------------------------------------------------------------------------
// gble_pkg
// Shared types and constants of the gap-buffer line editor.
// ----------------------------------------------------------------------------
package gble_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned PREVIEW = 10;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned LW      = $clog2(DEPTH + 1);
  localparam int unsigned PW      = $clog2(PREVIEW + 1);
  localparam int unsigned CW      = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LEFT   = 2'd2,
    REQ_RIGHT  = 2'd3
  } req_type_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef struct packed {
    logic [1:0]    req_type;
    logic [CW-1:0] char_in;
    logic [LW-1:0] count;
  } req_t;

  typedef struct packed {
    logic [LW-1:0] value;
    logic          has_char;
    logic          status;
    logic          last;
  } rsp_t;

endpackage

// File: rtl/gap_buffer_line_editor_top.sv
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_top
// Line-edit buffer kept as two character stacks around a cursor.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each result word
// shows on rsp_o for one cycle with strobe_o high and cannot be held off.
// Insert and delete give their word in the cycle after they are taken.
// A cursor move copies one character per cycle between the two stack RAMs
// (read of one, write of the other), then reads the preview one character
// per cycle from the left RAM, n preview words (n at most 10), with busy
// high throughout; when no character lies left of the cursor, the single
// empty word is sent instead.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  gble_pkg::req_t  req_i,
  output logic            strobe_o,
  output gble_pkg::rsp_t  rsp_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOVE   = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_PREV   = 3'd3;
  localparam logic [2:0] S_PWAIT  = 3'd4;

  localparam int unsigned AW = gble_pkg::AW;
  localparam int unsigned LW = gble_pkg::LW;
  localparam int unsigned PW = gble_pkg::PW;
  localparam int unsigned CW = gble_pkg::CW;
  localparam logic [LW-1:0] DEPTH_L   = LW'(gble_pkg::DEPTH);
  localparam logic [LW-1:0] PREVIEW_L = LW'(gble_pkg::PREVIEW);

  logic [2:0]     state_q, state_d;
  logic [LW-1:0]  left_len_q, left_len_d;
  logic [LW-1:0]  right_len_q, right_len_d;
  logic [LW-1:0]  cnt_q, cnt_d;
  logic           dir_right_q, dir_right_d;
  logic [PW-1:0]  n_q, n_d;
  logic [PW-1:0]  i_q, i_d;
  logic           wr_vld_q, wr_vld_d;
  logic [AW-1:0]  wr_addr_q, wr_addr_d;
  logic           rd_pend_q, rd_pend_d;
  logic           rd_last_q, rd_last_d;
  logic           strobe_q, strobe_d;
  gble_pkg::rsp_t rsp_q, rsp_d;

  logic          left_we, right_we;
  logic [AW-1:0] left_waddr, right_waddr, left_raddr, right_raddr;
  logic [CW-1:0] left_wdata, right_wdata, left_rdata, right_rdata;

  logic          accept;
  logic          full;
  logic          can_step;
  logic [LW-1:0] del_n;
  logic [LW-1:0] prev_addr;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign full   = ({1'b0, left_len_q} + {1'b0, right_len_q}) >= {1'b0, DEPTH_L};
  assign del_n  = (req_i.count < left_len_q) ? req_i.count : left_len_q;
  assign can_step = (cnt_q != '0) && (dir_right_q
                    ? (right_len_q != '0 && left_len_q != DEPTH_L)
                    : (left_len_q != '0 && right_len_q != DEPTH_L));
  assign prev_addr = left_len_q - LW'(n_q) + LW'(i_q);

  always_comb begin
    state_d     = state_q;
    left_len_d  = left_len_q;
    right_len_d = right_len_q;
    cnt_d       = cnt_q;
    dir_right_d = dir_right_q;
    n_d         = n_q;
    i_d         = i_q;
    wr_vld_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    rd_pend_d   = 1'b0;
    rd_last_d   = rd_last_q;
    strobe_d    = 1'b0;
    rsp_d       = rsp_q;

    left_we     = 1'b0;
    left_waddr  = wr_addr_q;
    left_wdata  = right_rdata;
    left_raddr  = AW'(left_len_q - LW'(1));
    right_we    = wr_vld_q && !dir_right_q;
    right_waddr = wr_addr_q;
    right_wdata = left_rdata;
    right_raddr = AW'(right_len_q - LW'(1));

    if (wr_vld_q && dir_right_q) begin
      left_we = 1'b1;
    end

    if (rd_pend_q) begin
      strobe_d = 1'b1;
      rsp_d    = '{value: LW'(left_rdata), has_char: 1'b1,
                   status: gble_pkg::STATUS_OK, last: rd_last_q};
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            gble_pkg::REQ_INSERT: begin
              strobe_d = 1'b1;
              rsp_d    = '{value: '0, has_char: 1'b0, status: gble_pkg::STATUS_FULL,
                           last: 1'b1};
              if (!full) begin
                left_we        = 1'b1;
                left_waddr     = left_len_q[AW-1:0];
                left_wdata     = req_i.char_in;
                left_len_d     = left_len_q + LW'(1);
                rsp_d.status   = gble_pkg::STATUS_OK;
              end
            end
            gble_pkg::REQ_DELETE: begin
              strobe_d   = 1'b1;
              rsp_d      = '{value: del_n, has_char: 1'b0,
                             status: gble_pkg::STATUS_OK, last: 1'b1};
              left_len_d = left_len_q - del_n;
            end
            default: begin
              cnt_d       = req_i.count;
              dir_right_d = (req_i.req_type == gble_pkg::REQ_RIGHT);
              state_d     = S_MOVE;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (can_step) begin
          cnt_d    = cnt_q - LW'(1);
          wr_vld_d = 1'b1;
          if (dir_right_q) begin
            right_len_d = right_len_q - LW'(1);
            left_len_d  = left_len_q + LW'(1);
            wr_addr_d   = left_len_q[AW-1:0];
          end else begin
            left_len_d  = left_len_q - LW'(1);
            right_len_d = right_len_q + LW'(1);
            wr_addr_d   = right_len_q[AW-1:0];
          end
        end else begin
          state_d = S_PSTART;
        end
      end
      S_PSTART: begin
        i_d = '0;
        if (left_len_q == '0) begin
          strobe_d = 1'b1;
          rsp_d    = '{value: '0, has_char: 1'b0, status: gble_pkg::STATUS_OK,
                       last: 1'b1};
          state_d  = S_IDLE;
        end else begin
          n_d     = (left_len_q < PREVIEW_L) ? left_len_q[PW-1:0] : PW'(gble_pkg::PREVIEW);
          state_d = S_PREV;
        end
      end
      S_PREV: begin
        left_raddr = prev_addr[AW-1:0];
        rd_pend_d  = 1'b1;
        rd_last_d  = (i_q == n_q - PW'(1));
        i_d        = i_q + PW'(1);
        if (i_q == n_q - PW'(1)) begin
          state_d = S_PWAIT;
        end
      end
      S_PWAIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      left_len_q  <= '0;
      right_len_q <= '0;
      cnt_q       <= '0;
      dir_right_q <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      wr_vld_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_len_q  <= left_len_d;
      right_len_q <= right_len_d;
      cnt_q       <= cnt_d;
      dir_right_q <= dir_right_d;
      n_q         <= n_d;
      i_q         <= i_d;
      wr_vld_q    <= wr_vld_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    rsp_q     <= rsp_d;
  end

  gble_ram #(.AW(AW), .DW(CW)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  gble_ram #(.AW(AW), .DW(CW)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (right_wdata),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, left_len_q} + {1'b0, right_len_q}) <= {1'b0, DEPTH_L})
    else $error("stack lengths exceed buffer depth");

  a_wr_after_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> ($past(state_q) == S_MOVE))
    else $error("copy write without a move step");

  a_prev_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREV) |-> (n_q != '0 && i_q < n_q))
    else $error("preview index out of range");

  a_move_len_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=>
      ({1'b0, left_len_q} + {1'b0, right_len_q}) ==
      $past({1'b0, left_len_q} + {1'b0, right_len_q}))
    else $error("cursor move changed total length");

  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && rsp_q.has_char) |-> (rsp_q.status == gble_pkg::STATUS_OK))
    else $error("preview word flagged full");

endmodule

// File: rtl/gble_ram.sv
// ----------------------------------------------------------------------------
// gble_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gble_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/line_editor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_checker
// Watches the request and result channels of the gap-buffer line editor.
// Keeps its own copy of both character stacks, predicts the result words of
// every accepted request and compares each strobed word field by field.
// ----------------------------------------------------------------------------
module line_editor_checker
  import gble_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic strobe_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [CW-1:0] left_chars  [DEPTH];
  logic [CW-1:0] right_chars [DEPTH];
  int unsigned   left_fill;
  int unsigned   right_fill;
  rsp_t          due_words [$];
  rsp_t          want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic void apply_request(input req_t r);
    rsp_t        w;
    int unsigned steps;
    int unsigned n;
    w      = '0;
    w.last = 1'b1;
    steps  = r.count;
    case (req_type_e'(r.req_type))
      REQ_INSERT: begin
        if (left_fill + right_fill >= DEPTH) begin
          w.status = STATUS_FULL;
        end else begin
          left_chars[left_fill] = r.char_in;
          left_fill++;
        end
        due_words.push_back(w);
        return;
      end
      REQ_DELETE: begin
        n = (steps < left_fill) ? steps : left_fill;
        left_fill -= n;
        w.value = LW'(n);
        due_words.push_back(w);
        return;
      end
      REQ_LEFT: begin
        while (steps > 0 && left_fill > 0 && right_fill < DEPTH) begin
          left_fill--;
          right_chars[right_fill] = left_chars[left_fill];
          right_fill++;
          steps--;
        end
      end
      default: begin
        while (steps > 0 && right_fill > 0 && left_fill < DEPTH) begin
          right_fill--;
          left_chars[left_fill] = right_chars[right_fill];
          left_fill++;
          steps--;
        end
      end
    endcase
    n = (left_fill < PREVIEW) ? left_fill : PREVIEW;
    if (n == 0) begin
      due_words.push_back(w);
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      w.value    = LW'(left_chars[left_fill - n + i]);
      w.has_char = 1'b1;
      w.last     = (i + 1 == n);
      due_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_fill  = 0;
      right_fill = 0;
      due_words.delete();
      pending_o  = 0;
    end else begin
      if (start_i && !busy_i) begin
        apply_request(req_i);
      end
      if (strobe_i) begin
        if (due_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word value=%0d has_char=%0b status=%0b last=%0b",
                                  rsp_i.value, rsp_i.has_char, rsp_i.status, rsp_i.last));
        end else begin
          want = due_words.pop_front();
          if (rsp_i.value !== want.value)
            flag_mismatch($sformatf("value %0d, want %0d", rsp_i.value, want.value));
          if (rsp_i.has_char !== want.has_char)
            flag_mismatch($sformatf("has_char %0b, want %0b", rsp_i.has_char, want.has_char));
          if (rsp_i.status !== want.status)
            flag_mismatch($sformatf("status %0b, want %0b", rsp_i.status, want.status));
          if (rsp_i.last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", rsp_i.last, want.last));
        end
      end
      pending_o = due_words.size();
    end
  end

endmodule

// File: dv/gap_buffer_line_editor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_top_test
// Drives requests into the gap-buffer line editor: a directed pass over empty
// stacks, edge counts and previews, then random editing with and without
// pauses between words.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_top_test;
  import gble_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic strobe_o;
  rsp_t rsp_o;
  int   fail_count;
  int   pending;
  bit   pace_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gap_buffer_line_editor_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .strobe_o(strobe_o),
    .rsp_o   (rsp_o)
  );

  line_editor_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .strobe_i    (strobe_o),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  task automatic send_word(input req_type_e kind, input logic [CW-1:0] ch,
                           input int unsigned cnt);
    req_t w;
    int   gap;
    w.req_type = kind;
    w.char_in  = ch;
    w.count    = LW'(cnt);
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    gap = pace_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      send_word(REQ_INSERT, CW'($urandom_range(0, 255)), $urandom_range(0, 4096));
    else if (pick < 62)
      send_word(REQ_DELETE, CW'($urandom_range(0, 255)), $urandom_range(0, 12));
    else if (pick < 94)
      send_word(pick[0] ? REQ_RIGHT : REQ_LEFT, CW'($urandom_range(0, 255)),
                $urandom_range(0, 15));
    else
      send_word(req_type_e'($urandom_range(1, 3)), CW'($urandom_range(0, 255)),
                $urandom_range(0, 4096));
  endtask

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    pace_on = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(REQ_DELETE, 8'h00, 5);
    send_word(REQ_LEFT, 8'hFF, 0);
    send_word(REQ_RIGHT, 8'h00, 4096);
    send_word(REQ_INSERT, 8'h00, 4096);
    send_word(REQ_INSERT, 8'hFF, 0);
    send_word(REQ_INSERT, 8'hA5, 1);
    send_word(REQ_INSERT, 8'h5A, 0);
    repeat (8) send_word(REQ_INSERT, CW'($urandom_range(0, 255)), 0);
    send_word(REQ_LEFT, 8'h00, 3);
    send_word(REQ_RIGHT, 8'h00, 0);
    send_word(REQ_LEFT, 8'hFF, 4096);
    send_word(REQ_RIGHT, 8'h00, 1);
    send_word(REQ_RIGHT, 8'h00, 4096);
    send_word(REQ_DELETE, 8'h00, 2);
    send_word(REQ_DELETE, 8'h00, 0);
    send_word(REQ_DELETE, 8'hFF, 4096);
    drain();

    for (int k = 0; k < 196; k++) begin
      pace_on = ((k / 40) % 2) == 0;
      if (k == 98) drain();
      random_request();
    end

    drain();
    repeat (32) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
